// ----- design/sha_pkg.sv -----
// shared types and constants of the sha-256 stream hasher
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_sha_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_sha_out;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [1:0] BSEL_DATA = 2'd0;
    localparam logic [1:0] BSEL_PAD  = 2'd1;
    localparam logic [1:0] BSEL_ZERO = 2'd2;
    localparam logic [1:0] BSEL_LEN  = 2'd3;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;

    typedef struct packed {
        logic       push;
        logic [1:0] byte_sel;
        logic       count_total;
        logic       latch_len;
        logic       start_round;
        logic       round;
        logic       add;
        logic       out_next;
        logic       restart;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
        logic       out_last;
    } t_dp_stat;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage
`default_nettype wire

// ----- design/sha256_stream_hasher.sv -----
// sha-256 stream hasher top level
//
// input channel (i_in_valid / o_in_ready / i_in_data): each request carries cmd and
// data_byte. cmd absorb adds one message byte, cmd finish pads the message and
// produces the digest. output channel (o_out_valid / i_out_ready / o_out_data):
// eight requests per finish, digest word 0 (most significant) first, last_word
// set on the eighth.
// an absorb request is accepted whenever the hasher is idle; the one that completes a
// 64-byte block is followed by the 64 rounds and a hash update, one round per
// cycle in the shared round unit, with the input not ready meanwhile.
// a finish request pushes the padding one byte per cycle (up to 72 bytes, with
// an idle step before the length bytes), each full block followed by a
// compression (the rounds and the hash update); after the final compression the
// digest is offered one word per cycle while the receiver is ready.
// a stalled receiver holds the current word steady and blocks further input.
// after the last word is taken the hash returns to its initial value.
// synchronous active-low reset loads the initial hash and clears the byte
// and length counters; no input is lost across a stall.
`default_nettype none
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_sha_in i_in_data,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_sha_out     o_out_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data_byte (i_in_data.data_byte),
        .o_stat      (w_stat),
        .o_out       (o_out_data)
    );

endmodule
`default_nettype wire

// ----- design/sha_dp.sv -----
// sha-256 datapath: message window, round unit, hash words, length and output
`default_nettype none
module sha_dp
    import sha_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    input  wire logic [7:0] i_data_byte,
    output t_dp_stat      o_stat,
    output t_sha_out      o_out
);

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [23:0] r_acc;
    logic [63:0] r_bits;
    logic [60:0] r_total;
    logic [5:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;

    logic [7:0]  n_byte;
    logic [31:0] n_word;
    logic [31:0] n_wnext;
    logic [31:0] n_t1;
    logic [31:0] n_t2;
    logic [31:0] n_s0;
    logic [31:0] n_s1;
    logic [31:0] n_bs0;
    logic [31:0] n_bs1;
    logic [31:0] n_ch;
    logic [31:0] n_maj;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    always_comb begin
        unique case (i_cmd.byte_sel)
            BSEL_DATA: n_byte = i_data_byte;
            BSEL_PAD:  n_byte = PAD_BYTE;
            BSEL_ZERO: n_byte = 8'h00;
            BSEL_LEN:  n_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];
            default:   n_byte = 8'h00;
        endcase
    end

    assign n_word = {r_acc, n_byte};

    assign n_s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign n_s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign n_wnext = n_s1 + r_w[9] + n_s0 + r_w[0];

    assign n_bs1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign n_bs0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign n_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign n_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign n_t1  = r_v[7] + n_bs1 + n_ch + ROUND_K[r_rnd] + r_w[0];
    assign n_t2  = n_bs0 + n_maj;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= H_INIT;
            r_fill  <= '0;
            r_total <= '0;
            r_rnd   <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.count_total) begin
                r_total <= r_total + 61'd1;
            end
            if (i_cmd.start_round) begin
                r_rnd <= '0;
            end else if (i_cmd.round) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (i_cmd.add) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            // index wraps to zero on the last word
            if (i_cmd.out_next) begin
                r_idx <= r_idx + 3'd1;
            end
            if (i_cmd.restart) begin
                r_h     <= H_INIT;
                r_fill  <= '0;
                r_total <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_len) begin
            r_bits <= {r_total, 3'b000};
        end
        if (i_cmd.push) begin
            r_acc <= n_word[23:0];
        end
        if (i_cmd.push && (r_fill[1:0] == 2'b11)) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= n_word;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= n_wnext;
        end
        if (i_cmd.start_round) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + n_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= n_t1 + n_t2;
        end
    end

    assign o_stat.fill       = r_fill;
    assign o_stat.round_last = (r_rnd == 6'd63);
    assign o_stat.out_last   = (r_idx == 3'd7);

    assign o_out.digest_word = r_h[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == 3'd7);

endmodule
`default_nettype wire

// ----- design/sha_ctrl.sv -----
// sha-256 controller: request handling, padding sequence, rounds and digest output
`default_nettype none
module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PAD80  = 3'd1;
    localparam logic [2:0] S_PADZ   = 3'd2;
    localparam logic [2:0] S_PADLEN = 3'd3;
    localparam logic [2:0] S_ROUND  = 3'd4;
    localparam logic [2:0] S_ADD    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_pad;
    logic       n_pad;
    logic       r_final;
    logic       n_final;
    logic       n_full;

    assign n_full = (i_stat.fill == FILL_LAST);

    always_comb begin
        n_state     = r_state;
        n_pad       = r_pad;
        n_final     = r_final;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_ABSORB) begin
                        o_cmd.push        = 1'b1;
                        o_cmd.byte_sel    = BSEL_DATA;
                        o_cmd.count_total = 1'b1;
                        if (n_full) begin
                            o_cmd.start_round = 1'b1;
                            n_state           = S_ROUND;
                        end
                    end else begin
                        o_cmd.latch_len = 1'b1;
                        n_pad           = 1'b1;
                        n_state         = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                o_cmd.push     = 1'b1;
                o_cmd.byte_sel = BSEL_PAD;
                if (n_full) begin
                    o_cmd.start_round = 1'b1;
                    n_state           = S_ROUND;
                end else begin
                    n_state = S_PADZ;
                end
            end
            S_PADZ: begin
                if (i_stat.fill == LEN_START) begin
                    n_state = S_PADLEN;
                end else begin
                    o_cmd.push     = 1'b1;
                    o_cmd.byte_sel = BSEL_ZERO;
                    if (n_full) begin
                        o_cmd.start_round = 1'b1;
                        n_state           = S_ROUND;
                    end
                end
            end
            S_PADLEN: begin
                o_cmd.push     = 1'b1;
                o_cmd.byte_sel = BSEL_LEN;
                if (n_full) begin
                    o_cmd.start_round = 1'b1;
                    n_final           = 1'b1;
                    n_state           = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_stat.round_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_final) begin
                    n_state = S_OUT;
                end else if (r_pad) begin
                    n_state = S_PADZ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.out_next = 1'b1;
                    if (i_stat.out_last) begin
                        o_cmd.restart = 1'b1;
                        n_pad         = 1'b0;
                        n_final       = 1'b0;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pad   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pad   <= n_pad;
            r_final <= n_final;
        end
    end

endmodule
`default_nettype wire
